// ----- sv/ssfd_pkg.sv -----
// shared types, constants and helpers of the sensor stream frame deframer
package ssfd_pkg;

  // default frame length limit in bytes
  localparam int unsigned MaxFrameBytesDefault = 2048;

  // depth of the queue between parser and output stage
  localparam int unsigned QueueDepth = 2;

  // first byte position of the sample area
  localparam int unsigned DataStart = 29;

  // acquisition type that marks a streaming frame
  localparam logic [7:0] AcqStreaming = 8'h03;

  // header byte positions
  localparam logic [4:0] PosDevice  = 5'd0;
  localparam logic [4:0] PosAcqType = 5'd1;
  localparam logic [4:0] PosSecsLo  = 5'd2;
  localparam logic [4:0] PosSecsHi  = 5'd5;
  localparam logic [4:0] PosMsLo    = 5'd6;
  localparam logic [4:0] PosMsHi    = 5'd7;
  localparam logic [4:0] PosRateLo  = 5'd8;
  localparam logic [4:0] PosRateHi  = 5'd9;
  localparam logic [4:0] PosMapLo   = 5'd10;
  localparam logic [4:0] PosMapHi   = 5'd13;
  localparam logic [4:0] PosCount   = 5'd14;
  localparam logic [4:0] PosSeqLo   = 5'd14;
  localparam logic [4:0] PosSeqHi   = 5'd16;
  localparam logic [4:0] PosRowsLo  = 5'd17;
  localparam logic [4:0] PosRowsHi  = 5'd18;
  localparam logic [4:0] PosPrevLo  = 5'd25;
  localparam logic [4:0] PosPrevHi  = 5'd26;
  localparam logic [4:0] PosFlags   = 5'd27;
  localparam logic [4:0] PosQuality = 5'd28;

  // highest device type that is kept
  localparam logic [7:0] DeviceMax = 8'd6;

  // byte of a 3-byte sample being collected
  typedef enum logic [1:0] {
    PhaseLow,
    PhaseMid,
    PhaseHigh
  } phase_e;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [23:0] sample_value;
    logic [4:0]         channel_slot;
    logic [15:0]        sample_row;
    logic [39:0]        subpacket_index;
    logic [23:0]        sequence_id;
    logic [31:0]        unix_seconds;
    logic [15:0]        reference_ms;
    logic [15:0]        sample_rate;
    logic [2:0]         device_kind;
    logic               sync_flag;
    logic [7:0]         link_quality;
    logic               last_in_frame;
  } out_item_t;

  // sample as handed from parser to output stage
  typedef struct packed {
    logic [23:0] raw_sample;
    logic [4:0]  slot;
    logic [15:0] row;
    logic        last;
    logic [39:0] base_index;
    logic [23:0] sequence_id;
    logic [31:0] seconds;
    logic [15:0] millis;
    logic [15:0] rate;
    logic [2:0]  device;
    logic        sync;
    logic [7:0]  quality;
  } entry_t;

  // entry with its valid flag
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // number of set bits in a 32-bit word, nibble by nibble
  function automatic logic [5:0] popcount32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 6'(v[4*i]) + 6'(v[4*i+1]) + 6'(v[4*i+2]) + 6'(v[4*i+3]);
    end
    return n;
  endfunction

endpackage

// ----- sv/ssfd_front.sv -----
// frame parser: byte position, header latching and sample assembly
module ssfd_front #(
  parameter int unsigned MaxFrameBytes = ssfd_pkg::MaxFrameBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ssfd_pkg::in_item_t item_i,
  output ssfd_pkg::push_t    push_o
);

  localparam int unsigned PosW = $clog2(MaxFrameBytes + 1);

  logic [PosW-1:0]      pos_q, pos_d, pos_cur;
  logic                 active_q, active_d, active_cur;
  logic [2:0]           dev_q, dev_d;
  logic [31:0]          sec_q, sec_d;
  logic [15:0]          ms_q, ms_d;
  logic [15:0]          rate_q, rate_d;
  logic [5:0]           ch_q, ch_d;
  logic [31:0]          map_q, map_d;
  logic [23:0]          seq_q, seq_d;
  logic [15:0]          rows_q, rows_d;
  logic [15:0]          prev_q, prev_d;
  logic [7:0]           flags_q, flags_d;
  logic [7:0]           qual_q, qual_d;
  logic [39:0]          base_q, base_d, base_prod;
  logic [7:0]           lo_q, lo_d, mid_q, mid_d;
  logic [4:0]           slot_q, slot_d;
  logic [15:0]          row_q, row_d;
  ssfd_pkg::phase_e     phase_q, phase_d;

  logic                 first;
  logic [7:0]           b;
  logic [4:0]           hdr_pos;
  logic [1:0]           sec_lane, map_lane, seq_lane;
  logic                 ms_lane, rate_lane, rows_lane, prev_lane;
  logic                 last_slot, last_row;

  // base index product, sized by the 40-bit context
  assign base_prod = seq_q * prev_q;

  // header lanes and end-of-row checks
  assign first     = item_i.first_byte;
  assign b         = item_i.data_byte;
  assign pos_cur   = first ? '0 : pos_q;
  assign active_cur = first | active_q;
  assign hdr_pos   = pos_cur[4:0];
  assign sec_lane  = 2'(hdr_pos - ssfd_pkg::PosSecsLo);
  assign map_lane  = 2'(hdr_pos - ssfd_pkg::PosMapLo);
  assign seq_lane  = 2'(hdr_pos - ssfd_pkg::PosSeqLo);
  assign ms_lane   = 1'(hdr_pos - ssfd_pkg::PosMsLo);
  assign rate_lane = 1'(hdr_pos - ssfd_pkg::PosRateLo);
  assign rows_lane = 1'(hdr_pos - ssfd_pkg::PosRowsLo);
  assign prev_lane = 1'(hdr_pos - ssfd_pkg::PosPrevLo);
  assign last_slot = (6'(slot_q) + 6'd1) >= ch_q;
  assign last_row  = (17'(row_q) + 17'd1) >= 17'(rows_q);

  // per-byte parsing
  always_comb begin
    pos_d    = pos_q;
    active_d = active_q;
    dev_d    = dev_q;
    sec_d    = sec_q;
    ms_d     = ms_q;
    rate_d   = rate_q;
    ch_d     = ch_q;
    map_d    = map_q;
    seq_d    = seq_q;
    rows_d   = rows_q;
    prev_d   = prev_q;
    flags_d  = flags_q;
    qual_d   = qual_q;
    base_d   = base_q;
    lo_d     = lo_q;
    mid_d    = mid_q;
    slot_d   = slot_q;
    row_d    = row_q;
    phase_d  = phase_q;

    push_o.valid             = 1'b0;
    push_o.entry.raw_sample  = {b, mid_q, lo_q};
    push_o.entry.slot        = slot_q;
    push_o.entry.row         = row_q;
    push_o.entry.last        = last_slot && last_row;
    push_o.entry.base_index  = base_q;
    push_o.entry.sequence_id = seq_q;
    push_o.entry.seconds     = sec_q;
    push_o.entry.millis      = ms_q;
    push_o.entry.rate        = rate_q;
    push_o.entry.device      = dev_q;
    push_o.entry.sync        = flags_q[0];
    push_o.entry.quality     = qual_q;

    if (accept_i) begin
      if (first) begin
        active_d = 1'b1;
        slot_d   = '0;
        row_d    = '0;
        phase_d  = ssfd_pkg::PhaseLow;
      end
      if (active_cur && pos_cur < PosW'(MaxFrameBytes)) begin
        pos_d = pos_cur + 1'b1;
        if (pos_cur < PosW'(ssfd_pkg::DataStart)) begin
          // header byte
          if (hdr_pos == ssfd_pkg::PosCount) begin
            ch_d = ssfd_pkg::popcount32(map_q);
          end
          if (hdr_pos == ssfd_pkg::PosFlags) begin
            base_d = base_prod;
          end
          if (hdr_pos == ssfd_pkg::PosDevice) begin
            dev_d = (b >= 8'd1 && b <= ssfd_pkg::DeviceMax) ? b[2:0] : 3'd0;
          end else if (hdr_pos == ssfd_pkg::PosAcqType) begin
            if (b != ssfd_pkg::AcqStreaming) begin
              active_d = 1'b0;
            end
          end else if (hdr_pos <= ssfd_pkg::PosSecsHi) begin
            sec_d[8*sec_lane +: 8] = b;
          end else if (hdr_pos <= ssfd_pkg::PosMsHi) begin
            ms_d[8*ms_lane +: 8] = b;
          end else if (hdr_pos <= ssfd_pkg::PosRateHi) begin
            rate_d[8*rate_lane +: 8] = b;
          end else if (hdr_pos <= ssfd_pkg::PosMapHi) begin
            map_d[8*map_lane +: 8] = b;
          end else if (hdr_pos <= ssfd_pkg::PosSeqHi) begin
            seq_d[8*seq_lane +: 8] = b;
          end else if (hdr_pos <= ssfd_pkg::PosRowsHi) begin
            rows_d[8*rows_lane +: 8] = b;
          end else if (hdr_pos >= ssfd_pkg::PosPrevLo && hdr_pos <= ssfd_pkg::PosPrevHi) begin
            prev_d[8*prev_lane +: 8] = b;
          end else if (hdr_pos == ssfd_pkg::PosFlags) begin
            flags_d = b;
          end else if (hdr_pos == ssfd_pkg::PosQuality) begin
            qual_d = b;
          end
        end else if (ch_q != '0 && row_q < rows_q) begin
          // sample byte, while samples remain
          unique case (phase_q)
            ssfd_pkg::PhaseLow: begin
              lo_d    = b;
              phase_d = ssfd_pkg::PhaseMid;
            end
            ssfd_pkg::PhaseMid: begin
              mid_d   = b;
              phase_d = ssfd_pkg::PhaseHigh;
            end
            ssfd_pkg::PhaseHigh: begin
              push_o.valid = 1'b1;
              phase_d      = ssfd_pkg::PhaseLow;
              if (last_slot) begin
                slot_d = '0;
                row_d  = row_q + 16'd1;
              end else begin
                slot_d = slot_q + 5'd1;
              end
            end
            default: begin
              phase_d = ssfd_pkg::PhaseLow;
            end
          endcase
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      active_q <= 1'b0;
      dev_q    <= '0;
      sec_q    <= '0;
      ms_q     <= '0;
      rate_q   <= '0;
      ch_q     <= '0;
      map_q    <= '0;
      seq_q    <= '0;
      rows_q   <= '0;
      prev_q   <= '0;
      flags_q  <= '0;
      qual_q   <= '0;
      base_q   <= '0;
      lo_q     <= '0;
      mid_q    <= '0;
      slot_q   <= '0;
      row_q    <= '0;
      phase_q  <= ssfd_pkg::PhaseLow;
    end else begin
      pos_q    <= pos_d;
      active_q <= active_d;
      dev_q    <= dev_d;
      sec_q    <= sec_d;
      ms_q     <= ms_d;
      rate_q   <= rate_d;
      ch_q     <= ch_d;
      map_q    <= map_d;
      seq_q    <= seq_d;
      rows_q   <= rows_d;
      prev_q   <= prev_d;
      flags_q  <= flags_d;
      qual_q   <= qual_d;
      base_q   <= base_d;
      lo_q     <= lo_d;
      mid_q    <= mid_d;
      slot_q   <= slot_d;
      row_q    <= row_d;
      phase_q  <= phase_d;
    end
  end

endmodule

// ----- sv/ssfd_queue.sv -----
// short queue of assembled samples between parser and output stage
module ssfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssfd_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            not_full_o,
  output ssfd_pkg::push_t head_o
);

  localparam int unsigned PtrW = (ssfd_pkg::QueueDepth > 1) ? $clog2(ssfd_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(ssfd_pkg::QueueDepth + 1);

  ssfd_pkg::entry_t mem_q [ssfd_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  // handshake with both neighbors
  assign not_full_o   = cnt_q != CntW'(ssfd_pkg::QueueDepth);
  assign do_push      = push_i.valid && not_full_o;
  assign do_pop       = pop_i && (cnt_q != '0);
  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(ssfd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(ssfd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/ssfd_back.sv -----
// output stage: sign conversion, subpacket index and output register
module ssfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssfd_pkg::push_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssfd_pkg::out_item_t out_item_o
);

  logic                valid_q;
  ssfd_pkg::out_item_t item_q, item_d;
  logic [23:0]         mag;

  // take the head whenever the output register is free or draining
  assign pop_o = head_i.valid && (!valid_q || out_ready_i);
  assign mag   = {1'b0, head_i.entry.raw_sample[22:0]};

  // result formatting
  always_comb begin
    item_d.sample_value    = head_i.entry.raw_sample[23] ? -mag : mag;
    item_d.channel_slot    = head_i.entry.slot;
    item_d.sample_row      = head_i.entry.row;
    item_d.subpacket_index = head_i.entry.base_index + 40'(head_i.entry.row);
    item_d.sequence_id     = head_i.entry.sequence_id;
    item_d.unix_seconds    = head_i.entry.seconds;
    item_d.reference_ms    = head_i.entry.millis;
    item_d.sample_rate     = head_i.entry.rate;
    item_d.device_kind     = head_i.entry.device;
    item_d.sync_flag       = head_i.entry.sync;
    item_d.link_quality    = head_i.entry.quality;
    item_d.last_in_frame   = head_i.entry.last;
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- sv/sensor_stream_frame_deframer.sv -----
// top level of the sensor stream frame deframer
// throughput: one byte item per cycle, sustained while the output is taken every cycle
// path of a sample: it is written into the sample queue at the edge that accepts its third byte,
//   then loaded into the output register once that register is free or draining
// input is held off only when the two-entry sample queue is full
// reset clears position, frame state, header fields and counters; no clearing pass
module sensor_stream_frame_deframer #(
  parameter int unsigned MaxFrameBytes = ssfd_pkg::MaxFrameBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssfd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssfd_pkg::out_item_t out_item_o
);

  ssfd_pkg::push_t push, head;
  logic            not_full, pop, accept;

  assign in_ready_o = not_full;
  assign accept     = in_valid_i && not_full;

  // byte parser
  ssfd_front #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (in_item_i),
    .push_o  (push)
  );

  // sample queue
  ssfd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop),
    .not_full_o(not_full),
    .head_o    (head)
  );

  // output stage
  ssfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
